// ----- hdl/cfda_pkg.sv -----
// shared constants and types for the cascade filter decimating accumulator
`default_nettype none
package cfda_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SAMPLE_W    = 16;
    localparam int INTEG_W     = 32;
    localparam int FRAC_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int SUM_W       = 32;

    localparam logic [COUNT_W-1:0] LENGTH_RESET = 16'd512;

    // filter output handed to the accumulator stage
    typedef struct packed {
        logic               valid;
        logic [INTEG_W-1:0] integ;
    } cfda_stage_t;

endpackage
`default_nettype wire

// ----- hdl/cfda_channels.sv -----
// valid/ready channel interfaces for samples, sums and configuration
`default_nettype none
interface cfda_sample_if;
    logic                         valid;
    logic                         ready;
    logic [cfda_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface cfda_sum_if;
    logic                      valid;
    logic                      ready;
    logic [cfda_pkg::SUM_W-1:0] sum_value;

    modport source (output valid, output sum_value, input ready);
    modport sink (input valid, input sum_value, output ready);
endinterface

interface cfda_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [cfda_pkg::COUNT_W-1:0] accumulation_length;

    modport source (output valid, output accumulation_length, input ready);
    modport sink (input valid, input accumulation_length, output ready);
endinterface
`default_nettype wire

// ----- hdl/cfda_filter.sv -----
// two cascaded integrators with feedback and fractional carry registers
`default_nettype none
module cfda_filter (
    input  wire logic            clk,
    input  wire logic            rst_n,
    cfda_sample_if.sink          samples,
    output cfda_pkg::cfda_stage_t stage,
    input  wire logic            take
);

    logic [cfda_pkg::INTEG_W-1:0] fi_reg, fi_next;
    logic [cfda_pkg::INTEG_W-1:0] si_reg, si_next;
    logic [cfda_pkg::FRAC_W-1:0]  ns_reg, ns_next;
    logic [cfda_pkg::FRAC_W-1:0]  ff_reg, ff_next;
    logic [cfda_pkg::FRAC_W-1:0]  sf_reg, sf_next;
    logic                         valid_reg, valid_next;

    logic [cfda_pkg::INTEG_W-1:0] x32;
    logic [cfda_pkg::INTEG_W-1:0] diff;
    logic [cfda_pkg::INTEG_W-1:0] diff_q;
    logic [cfda_pkg::FRAC_W:0]    k1;
    logic [cfda_pkg::FRAC_W:0]    k2;
    logic                         accept;

    assign samples.ready = !valid_reg || take;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        x32     = cfda_pkg::INTEG_W'(samples.sample[cfda_pkg::SAMPLE_BITS-1:0]);
        // scaled sample minus si/256 and fi/2, arithmetic shifts
        diff    = (x32 << 8)
                  - {{8{si_reg[31]}}, si_reg[31:8]}
                  - {fi_reg[31], fi_reg[31:1]};
        ns_next = {diff[3:0], ns_reg[7:4]};
        diff_q  = {{4{diff[31]}}, diff[31:4]};
        k1      = {1'b0, ff_reg} + {1'b0, ns_next};
        ff_next = k1[7:0];
        fi_next = fi_reg + diff_q + cfda_pkg::INTEG_W'(k1[8]);
        k2      = {1'b0, sf_reg} + {1'b0, ff_next};
        sf_next = k2[7:0];
        si_next = si_reg + fi_next + cfda_pkg::INTEG_W'(k2[8]);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fi_reg    <= '0;
            si_reg    <= '0;
            ns_reg    <= '0;
            ff_reg    <= '0;
            sf_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                fi_reg <= fi_next;
                si_reg <= si_next;
                ns_reg <= ns_next;
                ff_reg <= ff_next;
                sf_reg <= sf_next;
            end
        end
    end

    assign stage.valid = valid_reg;
    assign stage.integ = si_reg;

    // an accepted transaction always leaves a pending stage entry
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg)
        else $error("filter stage entry missing after accept");

    // a pending entry that is not taken keeps its integrator value
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !take |=> valid_reg && $stable(si_reg))
        else $error("pending filter entry overwritten");

endmodule
`default_nettype wire

// ----- hdl/cfda_accum.sv -----
// decimating accumulator with carry byte and output register
`default_nettype none
module cfda_accum (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfda_pkg::cfda_stage_t stage,
    output logic                      take,
    cfda_cfg_if.sink                  cfg,
    cfda_sum_if.source                sums
);

    logic [cfda_pkg::INTEG_W-1:0] acc_low_reg, acc_low_next;
    logic [7:0]                   acc_high_reg, acc_high_next;
    logic [cfda_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic [cfda_pkg::COUNT_W-1:0] len_reg;
    logic [cfda_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic                         out_valid_reg, out_valid_next;

    logic [cfda_pkg::INTEG_W:0]   wide_sum;
    logic [7:0]                   high_inc;
    logic [cfda_pkg::COUNT_W-1:0] cnt_inc;
    logic                         emit;

    assign cfg.ready = 1'b1;
    assign take      = stage.valid && (!out_valid_reg || sums.ready);

    always_comb
    begin
        wide_sum = {1'b0, acc_low_reg} + {1'b0, stage.integ};
        high_inc = acc_high_reg + 8'(wide_sum[cfda_pkg::INTEG_W]);
        cnt_inc  = cnt_reg + 1'b1;
        emit     = take && (cnt_inc == len_reg);

        acc_low_next  = acc_low_reg;
        acc_high_next = acc_high_reg;
        cnt_next      = cnt_reg;
        sum_next      = {high_inc, wide_sum[31:8]};
        if (take)
        begin
            if (emit)
            begin
                acc_low_next  = '0;
                acc_high_next = '0;
                cnt_next      = '0;
            end
            else
            begin
                acc_low_next  = wide_sum[cfda_pkg::INTEG_W-1:0];
                acc_high_next = high_inc;
                cnt_next      = cnt_inc;
            end
        end

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (sums.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_low_reg   <= '0;
            acc_high_reg  <= '0;
            cnt_reg       <= '0;
            len_reg       <= cfda_pkg::LENGTH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_low_reg   <= acc_low_next;
            acc_high_reg  <= acc_high_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                len_reg <= cfg.accumulation_length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            sum_reg <= sum_next;
    end

    assign sums.valid     = out_valid_reg;
    assign sums.sum_value = sum_reg;

    // a result never lands on an unread one
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_valid_reg || sums.ready)
        else $error("result register overwritten");

    // decimation restarts with an empty accumulator
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> cnt_reg == '0 && acc_low_reg == '0 && acc_high_reg == '0)
        else $error("accumulator not cleared after result");

endmodule
`default_nettype wire

// ----- hdl/cascade_filter_decimating_accumulator.sv -----
// top level: integrating filter followed by a decimating accumulator
//
// samples: one 16-bit converter sample per transaction (valid/ready).
// sums:    one 32-bit result per accumulation_length samples; carry byte in
//          bits 31..24, accumulator bits 31..8 below.
// cfg:     accumulation_length write channel, always ready; write it only
//          while no sample is in flight. a value of 0 means 65536 samples.
// result path: the sample that completes a block is registered in the filter
//          register when accepted, and its result in the result register when
//          the accumulator takes it, which a result waiting on sums can delay.
// throughput: one sample per cycle while sums is not stalling; the filter feedback
//          loop (two shifted subtracts and two integrator adds) sets the clock period.
// reset: integrators, fractions, accumulator and counter go to zero and
//          accumulation_length to 512; filter state is only cleared by reset.
// stall: while a result waits on sums, an empty filter register still takes
//          one more sample; after that samples.ready drops until sums.ready.
`default_nettype none
module cascade_filter_decimating_accumulator (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cfda_sample_if.sink samples,
    cfda_cfg_if.sink    cfg,
    cfda_sum_if.source  sums
);

    cfda_pkg::cfda_stage_t stage;
    logic                  take;

    cfda_filter u_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .stage   (stage),
        .take    (take)
    );

    cfda_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .take  (take),
        .cfg   (cfg),
        .sums  (sums)
    );

endmodule
`default_nettype wire

// ----- verif/cascade_filter_decimating_accumulator_tb.sv -----
// self-checking testbench for the cascade filter decimating accumulator
`timescale 1ns / 100ps
module cascade_filter_decimating_accumulator_tb;

    typedef enum logic {ROW_SAMPLE, ROW_LENGTH} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] value;
        bit          typed;
        logic [31:0] sum;
    } stim_row_t;

    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 300;
    localparam int ROW_COUNT     = 22;

    logic clk;
    logic rst_n;

    cfda_sample_if samples_ch ();
    cfda_cfg_if    cfg_ch ();
    cfda_sum_if    sums_ch ();

    cascade_filter_decimating_accumulator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .cfg     (cfg_ch),
        .sums    (sums_ch)
    );

    // filter and accumulator state of the predictor
    logic [31:0] integ1       = '0;
    logic [31:0] integ2       = '0;
    logic [7:0]  nib_shift    = '0;
    logic [7:0]  frac1        = '0;
    logic [7:0]  frac2        = '0;
    logic [31:0] acc_lo       = '0;
    logic [7:0]  acc_hi       = '0;
    logic [15:0] sample_count = '0;
    logic [15:0] acc_length   = 16'd512;

    logic [31:0] expected_sums[$];
    int          mismatch_count = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          hold_left      = 0;
    bit          hold_req       = 1'b0;

    // length rows write the register; typed sums hold from the all-zero state
    stim_row_t directed_rows [ROW_COUNT] = '{
        '{ROW_LENGTH, 16'd1,    1'b0, 32'h0},
        '{ROW_SAMPLE, 16'h0000, 1'b1, 32'h0000_0000},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 32'h0000_0FFF},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'h0000, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'h8000, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'h7FFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'h5555, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'hAAAA, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'h0001, 1'b0, 32'h0},
        '{ROW_LENGTH, 16'd3,    1'b0, 32'h0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 32'h0},
        '{ROW_LENGTH, 16'd2,    1'b0, 32'h0},
        '{ROW_SAMPLE, 16'h00F0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'h0F00, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'hF000, 1'b0, 32'h0},
        '{ROW_SAMPLE, 16'h000F, 1'b0, 32'h0}
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // advances the filter by one sample; returns 1 when a sum is due
    function automatic bit filter_step(input logic [15:0] smp, output logic [31:0] sum);
        logic [31:0]        x;
        logic [31:0]        d;
        logic signed [31:0] fb1;
        logic signed [31:0] fb2;
        logic signed [31:0] dsh;
        logic [8:0]         k;
        logic [32:0]        wide;
        bit                 emit;
        x = {16'd0, smp} & ((32'd1 << cfda_pkg::SAMPLE_BITS) - 32'd1);
        fb2 = $signed(integ2) >>> 8;
        fb1 = $signed(integ1) >>> 1;
        d = (x << 8) - fb2 - fb1;
        nib_shift = {d[3:0], nib_shift[7:4]};
        dsh = $signed(d) >>> 4;
        k = {1'b0, frac1} + {1'b0, nib_shift};
        frac1 = k[7:0];
        integ1 = integ1 + dsh + {31'd0, k[8]};
        k = {1'b0, frac2} + {1'b0, frac1};
        frac2 = k[7:0];
        integ2 = integ2 + integ1 + {31'd0, k[8]};
        wide = {1'b0, acc_lo} + {1'b0, integ2};
        acc_lo = wide[31:0];
        if (wide[32])
            acc_hi = acc_hi + 8'd1;
        sample_count = sample_count + 16'd1;
        emit = 1'b0;
        sum = '0;
        if (sample_count == acc_length)
        begin
            sum = {acc_hi, acc_lo[31:8]};
            sample_count = '0;
            acc_lo = '0;
            acc_hi = '0;
            emit = 1'b1;
        end
        return emit;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9, 0))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000 | 16'($urandom_range(255, 0));
            3: return 16'hFFFF - 16'($urandom_range(255, 0));
            default: return 16'($urandom_range(65535, 0));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic offer_sample(input logic [15:0] smp, input bit typed,
                                input logic [31:0] typed_sum);
        logic [31:0] sum;
        while (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= smp;
        do @(posedge clk); while (!samples_ch.ready);
        if (filter_step(smp, sum))
            expected_sums.push_back(typed ? typed_sum : sum);
    endtask

    // park the source and let every pending sum come out
    task automatic drain_results();
        samples_ch.valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [15:0] len);
        drain_results();
        cfg_ch.valid               <= 1'b1;
        cfg_ch.accumulation_length <= len;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        acc_length = len;
    endtask

    task automatic run_random(input int count, input logic [15:0] len);
        write_length(len);
        repeat (count) offer_sample(pick_sample(), 1'b0, 32'h0);
    endtask

    // sum sink: random stalls, long hold-off on request, checks every transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sums_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (sums_ch.valid && sums_ch.ready)
            begin
                if (expected_sums.size() == 0)
                    report_mismatch($sformatf("unexpected sum %h", sums_ch.sum_value));
                else if (sums_ch.sum_value !== expected_sums[0])
                begin
                    report_mismatch($sformatf("sum_value got %h want %h",
                                              sums_ch.sum_value, expected_sums[0]));
                    void'(expected_sums.pop_front());
                end
                else
                    void'(expected_sums.pop_front());
            end
            if (hold_req)
                hold_left = LONG_HOLD;
            if (hold_left > 0)
            begin
                hold_left--;
                sums_ch.ready <= 1'b0;
            end
            else
                sums_ch.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
        end
    end

    initial
    begin
        #4_000_000;
        $display("cascade_filter_decimating_accumulator verification failed");
        $finish;
    end

    initial
    begin
        int src_modes [4];
        int sink_modes [4];
        src_modes  = '{0, 82, 0, 36};
        sink_modes = '{0, 0, 82, 36};
        rst_n                      <= 1'b0;
        samples_ch.valid           <= 1'b0;
        samples_ch.sample          <= '0;
        cfg_ch.valid               <= 1'b0;
        cfg_ch.accumulation_length <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zeros keep the filter at rest, so this checks the reset length alone
        repeat (512) offer_sample(16'h0000, 1'b0, 32'h0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_LENGTH)
                write_length(directed_rows[i].value);
            else
                offer_sample(directed_rows[i].value, directed_rows[i].typed,
                             directed_rows[i].sum);
        end

        for (int m = 0; m < 4; m++)
        begin
            src_idle_pct   = src_modes[m];
            sink_stall_pct = sink_modes[m];
            run_random(45, 16'($urandom_range(3, 1)));
            run_random(45, 16'($urandom_range(24, 4)));
        end

        // sink holds off while the source keeps offering, then a full pause
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_length(16'd1);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (40) offer_sample(pick_sample(), 1'b0, 32'h0);
        drain_results();
        sink_stall_pct = 50;
        repeat (40) offer_sample(pick_sample(), 1'b0, 32'h0);

        // length dropped to zero below the running count: nothing due before the wrap
        sink_stall_pct = 0;
        run_random(20, 16'd40);
        write_length(16'd0);
        repeat (30) offer_sample(pick_sample(), 1'b0, 32'h0);

        src_idle_pct   = 36;
        sink_stall_pct = 36;
        run_random(60, 16'd5);

        drain_results();
        if (mismatch_count == 0)
            $display("cascade_filter_decimating_accumulator verification clean");
        else
            $display("cascade_filter_decimating_accumulator verification failed");
        $finish;
    end

endmodule
